// ----- sv/h264_annexb_nal_splitter_assert.svh -----
// Assertion shorthands shared by the NAL splitter RTL.
// Each expects clk_i and rst_ni in the enclosing scope.
`ifndef H264_ANNEXB_NAL_SPLITTER_ASSERT_SVH
`define H264_ANNEXB_NAL_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define H264NAL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("h264nal assertion failed");

// Next-cycle implication, checked outside reset.
`define H264NAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("h264nal assertion failed");

`endif

// ----- sv/h264nal_pkg.sv -----
`default_nettype none

package h264nal_pkg;

  // Header byte field and the NAL types that the parser tells apart
  localparam logic [7:0] NAL_TYPE_MASK   = 8'h1f;
  localparam logic [4:0] NAL_TYPE_SLICE  = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR    = 5'd5;
  localparam logic [4:0] NAL_TYPE_SPS    = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS    = 5'd8;

  // Start code bytes
  localparam logic [7:0] BYTE_ZERO       = 8'h00;
  localparam logic [7:0] BYTE_ONE        = 8'h01;

  // Zero run tracking: two zeros arm a start code, three is the ceiling
  localparam logic [1:0] ZERO_RUN_ARM    = 2'd2;
  localparam logic [1:0] ZERO_RUN_MAX    = 2'd3;

  typedef enum logic [1:0] {
    ACT_DISCARD = 2'd0,
    ACT_SPS     = 2'd1,
    ACT_PPS     = 2'd2,
    ACT_SAMPLE  = 2'd3
  } action_e;

  // One unit descriptor
  typedef struct packed {
    logic [4:0]  unit_type;
    logic [23:0] unit_length;
    logic        length_saturated;
    action_e     unit_action;
    logic [7:0]  profile_byte;
    logic [7:0]  compat_byte;
    logic [7:0]  level_byte;
    logic        final_unit;
  } desc_t;

endpackage

`default_nettype wire

// ----- sv/h264nal_parser.sv -----
`default_nettype none

module h264nal_parser
  import h264nal_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       eos_i,
  output logic            res_valid_o,
  output desc_t           res_o
);

  localparam int LB = LENGTH_BITS;
  localparam int SW = LB + 1;
  localparam int OW = (LB > 24) ? LB : 24;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  logic [1:0]    zero_run_q, zero_run_d;
  logic          inside_q, inside_d;
  logic [LB-1:0] count_q, count_d;
  logic [7:0]    header_q, header_d;
  logic [23:0]   ahb_q, ahb_d;
  logic          ovf_q, ovf_d;

  logic          is_zero, is_one, armed;
  logic [SW-1:0] sum_z, sum_zb, sum_fin;
  logic          emit_norm, emit_fin;
  logic [OW-1:0] len_norm_w, len_fin_w;
  logic [LB-1:0] len_fin;
  logic          ovf_fin;
  logic [4:0]    type_norm;
  action_e       act_norm;

  // Map a header type to its action
  function automatic action_e type_action(input logic [4:0] t);
    action_e a;
    a = ACT_DISCARD;
    if (t == NAL_TYPE_SPS) begin
      a = ACT_SPS;
    end else if (t == NAL_TYPE_PPS) begin
      a = ACT_PPS;
    end else if (t == NAL_TYPE_SLICE || t == NAL_TYPE_IDR) begin
      a = ACT_SAMPLE;
    end
    return a;
  endfunction

  assign is_zero = (byte_i == BYTE_ZERO);
  assign is_one  = (byte_i == BYTE_ONE);
  assign armed   = (zero_run_q >= ZERO_RUN_ARM);

  // Position of a committed byte after its pending zeros, and the count after it
  assign sum_z  = SW'(count_q) + SW'(zero_run_q);
  assign sum_zb = sum_z + SW'(1);

  // Next state for one byte
  always_comb begin
    zero_run_d = zero_run_q;
    inside_d   = inside_q;
    count_d    = count_q;
    header_d   = header_q;
    ahb_d      = ahb_q;
    ovf_d      = ovf_q;
    emit_norm  = 1'b0;
    if (!inside_q) begin
      if (is_zero) begin
        if (zero_run_q != ZERO_RUN_MAX) begin
          zero_run_d = zero_run_q + 2'd1;
        end
      end else if (is_one && armed) begin
        inside_d   = 1'b1;
        zero_run_d = '0;
        count_d    = '0;
        header_d   = '0;
        ahb_d      = '0;
        ovf_d      = 1'b0;
      end else begin
        zero_run_d = '0;
      end
    end else if (count_q == '0) begin
      // Header byte, even if zero
      header_d = byte_i;
      count_d  = LB'(1);
    end else if (is_zero) begin
      if (zero_run_q == ZERO_RUN_MAX) begin
        // Oldest pending zero joins the unit
        if (count_q == LEN_MAX) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + LB'(1);
        end
      end else begin
        zero_run_d = zero_run_q + 2'd1;
      end
    end else if (is_one && armed) begin
      emit_norm  = 1'b1;
      zero_run_d = '0;
      count_d    = '0;
      header_d   = '0;
      ahb_d      = '0;
      ovf_d      = 1'b0;
    end else begin
      // Commit pending zeros, then this byte
      if (sum_z == SW'(1)) begin
        ahb_d[23:16] = byte_i;
      end else if (sum_z == SW'(2)) begin
        ahb_d[15:8] = byte_i;
      end else if (sum_z == SW'(3)) begin
        ahb_d[7:0] = byte_i;
      end
      if (sum_zb > SW'(LEN_MAX)) begin
        count_d = LEN_MAX;
        ovf_d   = 1'b1;
      end else begin
        count_d = sum_zb[LB-1:0];
      end
      zero_run_d = '0;
    end
    if (eos_i) begin
      zero_run_d = '0;
      inside_d   = 1'b0;
      count_d    = '0;
      header_d   = '0;
      ahb_d      = '0;
      ovf_d      = 1'b0;
    end
  end

  // Final unit: pending zeros count as unit bytes
  assign emit_fin = eos_i && !emit_norm && inside_q && (inside_d || eos_i)
                    && (count_q != '0 || !(is_one && armed) || !inside_q)
                    && 1'b1;

  // Unit state as it stands after this byte, before the end-of-stream clear
  logic          in_post;
  logic [LB-1:0] cnt_post;
  logic [1:0]    zr_post;
  logic          ovf_post;
  logic [7:0]    hdr_post;

  always_comb begin
    in_post  = inside_q;
    cnt_post = count_q;
    zr_post  = zero_run_q;
    ovf_post = ovf_q;
    hdr_post = header_q;
    if (!inside_q) begin
      in_post = is_one && armed;
      cnt_post = '0;
      zr_post  = '0;
      ovf_post = 1'b0;
      hdr_post = '0;
    end else if (count_q == '0) begin
      cnt_post = LB'(1);
      hdr_post = byte_i;
    end else if (is_zero) begin
      if (zero_run_q == ZERO_RUN_MAX) begin
        if (count_q == LEN_MAX) begin
          ovf_post = 1'b1;
        end else begin
          cnt_post = count_q + LB'(1);
        end
      end else begin
        zr_post = zero_run_q + 2'd1;
      end
    end else if (is_one && armed) begin
      cnt_post = '0;
      zr_post  = '0;
    end else begin
      zr_post = '0;
      if (sum_zb > SW'(LEN_MAX)) begin
        cnt_post = LEN_MAX;
        ovf_post = 1'b1;
      end else begin
        cnt_post = sum_zb[LB-1:0];
      end
    end
  end

  assign sum_fin = SW'(cnt_post) + SW'(zr_post);
  assign ovf_fin = ovf_post || (sum_fin > SW'(LEN_MAX));
  assign len_fin = (sum_fin > SW'(LEN_MAX)) ? LEN_MAX : sum_fin[LB-1:0];

  logic fin_take;
  assign fin_take = eos_i && !emit_norm && in_post && (cnt_post != '0);

  assign type_norm  = header_q[4:0] & NAL_TYPE_MASK[4:0];
  assign act_norm   = type_action(type_norm);
  assign len_norm_w = OW'(count_q);
  assign len_fin_w  = OW'(len_fin);

  // Build the descriptor for this byte
  always_comb begin
    res_o = '0;
    if (emit_norm) begin
      res_o.unit_type        = type_norm;
      res_o.unit_length      = len_norm_w[23:0];
      res_o.length_saturated = ovf_q;
      res_o.unit_action      = act_norm;
      if (act_norm == ACT_SPS) begin
        res_o.profile_byte = ahb_q[23:16];
        res_o.compat_byte  = ahb_q[15:8];
        res_o.level_byte   = ahb_q[7:0];
      end
    end else begin
      res_o.unit_type        = hdr_post[4:0] & NAL_TYPE_MASK[4:0];
      res_o.unit_length      = len_fin_w[23:0];
      res_o.length_saturated = ovf_fin;
      res_o.unit_action      = ACT_SAMPLE;
      res_o.final_unit       = 1'b1;
    end
  end

  assign res_valid_o = fire_i && (emit_norm || (fin_take && emit_fin));

  // Advance the parse state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
      inside_q   <= 1'b0;
      count_q    <= '0;
      header_q   <= '0;
      ahb_q      <= '0;
      ovf_q      <= 1'b0;
    end else if (fire_i) begin
      zero_run_q <= zero_run_d;
      inside_q   <= inside_d;
      count_q    <= count_d;
      header_q   <= header_d;
      ahb_q      <= ahb_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/h264_annexb_nal_splitter.sv -----
// The descriptor of a unit is registered into the output slot, or the one-entry
// skid slot while m_axis stalls, from the beat that closes it (the start code's
// 01 byte or the end-of-stream beat). Throughput: one stream byte per cycle while
// the skid slot is empty; the parse update and the result register sit in a single
// stage. Reset: rst_ni clears the parse state and both slot flags, not the payloads.
`default_nettype none
`include "h264_annexb_nal_splitter_assert.svh"

module h264_annexb_nal_splitter
  import h264nal_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] stream_byte
  input  wire logic        s_axis_tlast,  // end_of_stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [4:0] unit_type, [28:5] unit_length, [29] length_saturated,
  // [37:30] profile_byte, [45:38] constraint_byte, [53:46] level_byte, [55:54] zero
  output logic [55:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,  // [1:0] unit_action
  output logic             m_axis_tlast   // final_unit
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam int OW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;
  localparam logic [OW-1:0] LEN_MAX_W = OW'(LEN_MAX);

  logic  s_fire, m_fire;
  logic  res_valid;
  desc_t res;
  logic  out_v_q, out_v_d;
  logic  skid_v_q, skid_v_d;
  desc_t out_q, out_d;
  desc_t skid_q, skid_d;

  assign s_axis_tready = !skid_v_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = out_v_q && m_axis_tready;

  h264nal_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s_fire),
    .byte_i     (s_axis_tdata),
    .eos_i      (s_axis_tlast),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Steer results into the output slot or the skid slot
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (m_fire) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_q || m_fire) begin
        out_d   = res;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res;
        skid_v_d = 1'b1;
      end
    end else if (m_fire) begin
      out_v_d = 1'b0;
    end
  end

  // Hold the slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Hold the slot payloads
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Pack the output beat
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_q.level_byte, out_q.compat_byte, out_q.profile_byte,
                          out_q.length_saturated, out_q.unit_length, out_q.unit_type};
  assign m_axis_tuser  = out_q.unit_action;
  assign m_axis_tlast  = out_q.final_unit;

  `H264NAL_ASSERT_IMPL(a_skid_behind_out, skid_v_q, out_v_q)
  `H264NAL_ASSERT_IMPL(a_final_is_sample, out_v_q && out_q.final_unit, out_q.unit_action == ACT_SAMPLE)
  `H264NAL_ASSERT_IMPL(a_sps_bytes_only, out_v_q && out_q.unit_action != ACT_SPS, m_axis_tdata[53:30] == 24'd0)
  `H264NAL_ASSERT_IMPL(a_sat_at_max, out_v_q && out_q.length_saturated, out_q.unit_length == LEN_MAX_W[23:0])
  `H264NAL_ASSERT_NEXT(a_result_lands, s_fire && res_valid, out_v_q)

endmodule

`default_nettype wire

// ----- tb/h264_annexb_nal_splitter_tb.sv -----
`timescale 1ns / 1ps

module h264_annexb_nal_splitter_tb;
  import h264nal_pkg::*;

  localparam int        RANDOM_BEATS = 900;
  localparam int        IDLE_LIMIT   = 2000;
  localparam int        LONG_HOLD    = 400;
  localparam int        HOLD_AT_UNIT = 30;
  localparam logic [23:0] LEN_MAX    = 24'hffffff;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic       drain;
  } beat_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  h264_annexb_nal_splitter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Stream bytes still to send and descriptors still owed by the block
  beat_t pending_bytes[$];
  desc_t owed_descs[$];

  // Parser state mirror
  logic [1:0]  zrun;
  logic        in_unit;
  logic [23:0] nbytes;
  logic [7:0]  hdr;
  logic [23:0] after_hdr;
  logic        len_ovf;

  int tx_gap;
  int tx_launched;
  int rx_wait;
  int rx_hold;
  int units_seen;
  int n_fail;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Unit parser mirror
  // ---------------------------------------------------------------------------
  task automatic open_unit();
    zrun      = '0;
    nbytes    = '0;
    hdr       = '0;
    after_hdr = '0;
    len_ovf   = 1'b0;
  endtask

  task automatic take_byte(input logic [7:0] v);
    if (nbytes >= 1 && nbytes <= 3) after_hdr[(3 - nbytes) * 8 +: 8] = v;
    if (nbytes < LEN_MAX) nbytes = nbytes + 1'b1;
    else len_ovf = 1'b1;
  endtask

  task automatic flush_zeros();
    while (zrun > 0) begin
      take_byte(BYTE_ZERO);
      zrun = zrun - 1'b1;
    end
  endtask

  task automatic owe_desc(input logic last_unit);
    desc_t      d;
    logic [7:0] masked;
    masked = hdr & NAL_TYPE_MASK;
    d.unit_type = masked[4:0];
    if (last_unit) d.unit_action = ACT_SAMPLE;
    else if (d.unit_type == NAL_TYPE_SPS) d.unit_action = ACT_SPS;
    else if (d.unit_type == NAL_TYPE_PPS) d.unit_action = ACT_PPS;
    else if (d.unit_type == NAL_TYPE_SLICE || d.unit_type == NAL_TYPE_IDR)
      d.unit_action = ACT_SAMPLE;
    else d.unit_action = ACT_DISCARD;
    d.unit_length      = nbytes;
    d.length_saturated = len_ovf;
    // Profile, compat and level only travel with a sequence set
    if (d.unit_action == ACT_SPS && !last_unit) begin
      d.profile_byte = after_hdr[23:16];
      d.compat_byte  = after_hdr[15:8];
      d.level_byte   = after_hdr[7:0];
    end else begin
      d.profile_byte = '0;
      d.compat_byte  = '0;
      d.level_byte   = '0;
    end
    d.final_unit = last_unit;
    owed_descs.push_back(d);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    logic closed;
    closed = 1'b0;
    if (!in_unit) begin
      if (b == BYTE_ZERO) begin
        if (zrun < ZERO_RUN_MAX) zrun = zrun + 1'b1;
      end else if (b == BYTE_ONE && zrun >= ZERO_RUN_ARM) begin
        in_unit = 1'b1;
        open_unit();
      end else begin
        zrun = '0;
      end
    end else if (nbytes == 0) begin
      // first byte after a start code is the header, zero or not
      hdr = b;
      take_byte(b);
    end else if (b == BYTE_ZERO) begin
      if (zrun >= ZERO_RUN_MAX) take_byte(BYTE_ZERO);
      else zrun = zrun + 1'b1;
    end else if (b == BYTE_ONE && zrun >= ZERO_RUN_ARM) begin
      owe_desc(1'b0);
      closed = 1'b1;
      open_unit();
    end else begin
      flush_zeros();
      take_byte(b);
    end

    // End of stream closes a non-empty unit and resets everything
    if (eos) begin
      if (!closed && in_unit && nbytes > 0) begin
        flush_zeros();
        owe_desc(1'b1);
      end
      in_unit = 1'b0;
      open_unit();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  task automatic add_beat(input logic [7:0] b, input logic eos, input logic drain);
    beat_t t;
    t.b     = b;
    t.eos   = eos;
    t.drain = drain;
    pending_bytes.push_back(t);
  endtask

  task automatic add_stream(input logic drain);
    int         units;
    int         zeros;
    int         plen;
    int         garbage;
    logic [7:0] v;
    logic [7:0] hb;
    logic       last;

    // Noise: short runs of zeros, ones and random bytes with random end marks
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 2))
          0:       v = BYTE_ZERO;
          1:       v = BYTE_ONE;
          default: v = 8'($urandom);
        endcase
        add_beat(v, $urandom_range(0, 7) == 0, drain);
        drain = 1'b0;
      end
      return;
    end

    // Leading bytes other than zero and one; the parser drops them outside a unit
    garbage = $urandom_range(0, 3);
    repeat (garbage) begin
      add_beat(8'($urandom_range(2, 255)), 1'b0, drain);
      drain = 1'b0;
    end

    units = $urandom_range(1, 5);
    for (int u = 0; u < units; u++) begin
      last  = (u == units - 1);
      zeros = $urandom_range(2, 3);
      if ($urandom_range(0, 5) == 0) zeros += $urandom_range(1, 3);
      repeat (zeros) begin
        add_beat(BYTE_ZERO, 1'b0, drain);
        drain = 1'b0;
      end
      // Stream may end right on the start code
      if (last && $urandom_range(0, 7) == 0) begin
        add_beat(BYTE_ONE, 1'b1, 1'b0);
        return;
      end
      add_beat(BYTE_ONE, 1'b0, 1'b0);

      hb = 8'($urandom);
      case ($urandom_range(0, 6))
        0:       hb[4:0] = NAL_TYPE_SLICE;
        1:       hb[4:0] = NAL_TYPE_IDR;
        2, 3:    hb[4:0] = NAL_TYPE_SPS;
        4:       hb[4:0] = NAL_TYPE_PPS;
        5:       hb = ($urandom_range(0, 1) == 0) ? 8'h06 : 8'h00;
        default: ;
      endcase
      plen = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      add_beat(hb, last && plen == 0, 1'b0);

      for (int k = 0; k < plen; k++) begin
        case ($urandom_range(0, 7))
          0, 1:    v = BYTE_ZERO;
          2:       v = BYTE_ONE;
          default: v = 8'($urandom);
        endcase
        add_beat(v, last && k == plen - 1, 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    beat_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);

      // Advance once the current beat is gone or nothing is offered
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          tx_gap        <= tx_gap - 1;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain && owed_descs.size() != 0)) begin
          nxt = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.b;
          s_axis_tlast  <= nxt.eos;
          tx_launched++;
          // Keep offering while the receiver holds off; alternate busy stretches
          if (rx_hold > 0 || ((tx_launched / 64) % 2) == 1) tx_gap <= 0;
          else tx_gap <= $urandom_range(0, 19);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Descriptor monitor and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_descs
    desc_t got;
    desc_t want;
    int    wait_n;
    int    hold_n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
      rx_hold       <= 0;
    end else begin
      wait_n = rx_wait;
      hold_n = rx_hold;
      if (m_axis_tvalid && m_axis_tready) begin
        got.unit_type        = m_axis_tdata[4:0];
        got.unit_length      = m_axis_tdata[28:5];
        got.length_saturated = m_axis_tdata[29];
        got.profile_byte     = m_axis_tdata[37:30];
        got.compat_byte      = m_axis_tdata[45:38];
        got.level_byte       = m_axis_tdata[53:46];
        got.unit_action      = action_e'(m_axis_tuser);
        got.final_unit       = m_axis_tlast;
        if (owed_descs.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: descriptor with none owed: type=%0d len=%0d act=%0d final=%0b",
                     $realtime, got.unit_type, got.unit_length, got.unit_action,
                     got.final_unit);
          n_fail++;
        end else begin
          want = owed_descs.pop_front();
          if (got.unit_type !== want.unit_type || got.unit_length !== want.unit_length ||
              got.length_saturated !== want.length_saturated ||
              got.unit_action !== want.unit_action ||
              got.profile_byte !== want.profile_byte ||
              got.compat_byte !== want.compat_byte ||
              got.level_byte !== want.level_byte || got.final_unit !== want.final_unit) begin
            if (n_fail < 10) begin
              $display("%0t: descriptor %0d differs", $realtime, units_seen);
              $display("  exp type=%0d len=%0d sat=%0b act=%0d prof=%h comp=%h lvl=%h fin=%0b",
                       want.unit_type, want.unit_length, want.length_saturated,
                       want.unit_action, want.profile_byte, want.compat_byte,
                       want.level_byte, want.final_unit);
              $display("  got type=%0d len=%0d sat=%0b act=%0d prof=%h comp=%h lvl=%h fin=%0b",
                       got.unit_type, got.unit_length, got.length_saturated,
                       got.unit_action, got.profile_byte, got.compat_byte,
                       got.level_byte, got.final_unit);
            end
            n_fail++;
          end
        end
        units_seen++;
        wait_n = (((units_seen / 16) % 2) == 1) ? 0 : $urandom_range(0, 19);
        // One long hold-off so the block backs up into its input
        if (units_seen == HOLD_AT_UNIT) hold_n = LONG_HOLD;
      end

      if (hold_n > 0) begin
        hold_n--;
        m_axis_tready <= 1'b0;
      end else if (wait_n > 0) begin
        wait_n--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      rx_wait <= wait_n;
      rx_hold <= hold_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles without any beat on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tx_launched = 0;
    units_seen  = 0;
    n_fail      = 0;
    idle_cycles = 0;
    in_unit     = 1'b0;
    open_unit();

    // Junk before the first start code, then a full sequence set
    add_beat(8'hab, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ONE, 1'b0, 1'b0);
    add_beat({3'b011, NAL_TYPE_SPS}, 1'b0, 1'b0);
    add_beat(8'hff, 1'b0, 1'b0);
    add_beat(8'h80, 1'b0, 1'b0);
    // Long zero run: the fourth zero becomes a unit byte, then a start code
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ONE, 1'b0, 1'b0);
    // Zero header byte, short unit
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(8'hff, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ONE, 1'b0, 1'b0);
    // Final unit with a sequence-set header and a pending zero at the end
    add_beat({3'b111, NAL_TYPE_SPS}, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b1, 1'b0);
    // Stream ending on a start code that closes a unit
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ONE, 1'b0, 1'b0);
    add_beat({3'b010, NAL_TYPE_PPS}, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ONE, 1'b1, 1'b0);
    // Stream with no start code at all
    add_beat(BYTE_ZERO, 1'b0, 1'b0);
    add_beat(BYTE_ONE, 1'b1, 1'b0);

    // Random streams; the first and some others wait for the block to drain
    add_stream(1'b1);
    while (pending_bytes.size() < RANDOM_BEATS + 28)
      add_stream($urandom_range(0, 5) == 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (owed_descs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (n_fail == 0 && owed_descs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
